[hdl/scalar_kalman_filter_macros.svh]
// ----------------------------------------------------------------------------
// Scalar Kalman filter assertion macros
// Concurrent checks on the block clock, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define SKF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define SKF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SKF_ASSERT(lbl, prop, msg)
`define SKF_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[hdl/skf_pkg.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Request and register codes, and the controller to datapath command bundle.
// ----------------------------------------------------------------------------
package skf_pkg;

  // request kinds carried in the input tuser
  localparam logic [1:0] REQ_PREDICT = 2'd0;
  localparam logic [1:0] REQ_UPDATE  = 2'd1;
  localparam logic [1:0] REQ_INIT    = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_PROCESS_NOISE      = 2'd0;
  localparam logic [1:0] CFG_SENSOR_NOISE       = 2'd1;
  localparam logic [1:0] CFG_INITIAL_ESTIMATE   = 2'd2;
  localparam logic [1:0] CFG_INITIAL_COVARIANCE = 2'd3;

  // datapath commands
  typedef struct packed {
    logic predict;    // P <= sat(P + Q)
    logic init;       // reload X and P from config
    logic upd_start;  // set up gain division and |z - X|
    logic div_step;   // one restoring division step
    logic mul_go;     // issue one partial product
    logic mul_hi;     // upper half of the wide operand
    logic mul_cov;    // operands P and 1-K instead of |z - X| and K
    logic acc_first;  // accumulator <= low partial product
    logic acc_add;    // accumulator += high partial product, shifted
    logic est_write;  // X <= X +/- step
    logic cov_write;  // P <= scaled P
    logic out_load;   // capture X and P into the output register
  } skf_cmd_t;

endpackage

[hdl/skf_ctrl.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter controller
// Sequences predict, init and update work and owns the output valid flag.
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_macros.svh"

module skf_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output skf_pkg::skf_cmd_t cmd
);
  import skf_pkg::*;

  localparam int CW = $clog2(FRAC_BITS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_ML0  = 4'd2;
  localparam logic [3:0] S_ML1  = 4'd3;
  localparam logic [3:0] S_ML2  = 4'd4;
  localparam logic [3:0] S_EST  = 4'd5;
  localparam logic [3:0] S_CV0  = 4'd6;
  localparam logic [3:0] S_CV1  = 4'd7;
  localparam logic [3:0] S_CV2  = 4'd8;
  localparam logic [3:0] S_CVW  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          out_valid_next;
  logic          slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req)
            REQ_PREDICT: begin
              cmd.predict = 1'b1;
              state_next  = S_FIN;
            end
            REQ_UPDATE: begin
              cmd.upd_start = 1'b1;
              cnt_next      = '0;
              state_next    = S_DIV;
            end
            REQ_INIT: begin
              cmd.init   = 1'b1;
              state_next = S_FIN;
            end
            REQ_NONE: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CW'(FRAC_BITS - 1)) begin
          state_next = S_ML0;
        end
      end
      S_ML0: begin
        cmd.mul_go = 1'b1;
        state_next = S_ML1;
      end
      S_ML1: begin
        cmd.mul_go    = 1'b1;
        cmd.mul_hi    = 1'b1;
        cmd.acc_first = 1'b1;
        state_next    = S_ML2;
      end
      S_ML2: begin
        cmd.acc_add = 1'b1;
        state_next  = S_EST;
      end
      S_EST: begin
        cmd.est_write = 1'b1;
        state_next    = S_CV0;
      end
      S_CV0: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_cov = 1'b1;
        state_next  = S_CV1;
      end
      S_CV1: begin
        cmd.mul_go    = 1'b1;
        cmd.mul_hi    = 1'b1;
        cmd.mul_cov   = 1'b1;
        cmd.acc_first = 1'b1;
        state_next    = S_CV2;
      end
      S_CV2: begin
        cmd.acc_add = 1'b1;
        state_next  = S_CVW;
      end
      S_CVW: begin
        cmd.cov_write = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when the beat is taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `SKF_ASSERT(a_load_slot_free, cmd.out_load |-> (!out_valid || out_ready), "output overwritten")
  `SKF_ASSERT(a_update_enters_div, (in_valid && in_ready && in_req == REQ_UPDATE) |=> (state == S_DIV), "update did not start division")
  `SKF_ASSERT(a_rise_after_fin, $rose(out_valid) |-> ($past(state) == S_FIN), "result shown outside finish")
  `SKF_ASSERT_NEVER(a_busy_accept, in_ready && (state != S_IDLE), "input taken while busy")

endmodule

[hdl/skf_datapath.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter datapath
// Config registers, filter state, serial gain divider, split multiplier and
// output register.
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_macros.svh"

module skf_datapath #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  skf_pkg::skf_cmd_t            cmd,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_data,
  input  logic signed [DATA_WIDTH-1:0] measurement,
  output logic signed [DATA_WIDTH-1:0] estimate_out,
  output logic [DATA_WIDTH-1:0]        covariance_out
);
  import skf_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int AW    = DATA_WIDTH + 1;     // |z - X| and P + R
  localparam int KW    = FRAC_BITS + 1;      // gain, 0 .. 1.0
  localparam int LO_W  = (AW + 1) / 2;       // multiplier operand half
  localparam int PW    = LO_W + KW;          // partial product
  localparam int ACC_W = AW + KW;            // full product

  localparam logic [KW-1:0] ONE_K = KW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;

  // configuration
  logic [DW-1:0]        process_noise, sensor_noise, initial_covariance;
  logic signed [DW-1:0] initial_estimate;

  // filter state
  logic signed [DW-1:0] estimate;
  logic [DW-1:0]        covariance;

  // update working registers
  logic [AW-1:0]    denom, rem, mag;
  logic             neg;
  logic [KW-1:0]    gain;
  logic             gain_fixed;
  logic [PW-1:0]    prod;
  logic [ACC_W-1:0] acc;

  logic [AW-1:0]    pr_sum, q_sum, diff, est_sum;
  logic [AW:0]      rem_sh, rem_sub;
  logic             rem_ge;
  logic [AW-1:0]    mul_a;
  logic [LO_W-1:0]  mul_a_half;
  logic [KW-1:0]    mul_b;
  logic [AW-1:0]    step;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise      <= '0;
      sensor_noise       <= ONE_D;
      initial_estimate   <= '0;
      initial_covariance <= ONE_D;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROCESS_NOISE:      process_noise      <= cfg_data;
        CFG_SENSOR_NOISE:       sensor_noise       <= cfg_data;
        CFG_INITIAL_ESTIMATE:   initial_estimate   <= cfg_data;
        CFG_INITIAL_COVARIANCE: initial_covariance <= cfg_data;
      endcase
    end
  end

  // adders around the state
  assign q_sum   = {1'b0, covariance} + {1'b0, process_noise};
  assign pr_sum  = {1'b0, covariance} + {1'b0, sensor_noise};
  assign diff    = {measurement[DW-1], measurement} - {estimate[DW-1], estimate};
  assign step    = acc[FRAC_BITS +: AW];
  assign est_sum = neg ? ({estimate[DW-1], estimate} - step)
                       : ({estimate[DW-1], estimate} + step);

  // restoring division step: remainder stays below the denominator
  assign rem_sh  = {rem, 1'b0};
  assign rem_ge  = (rem_sh >= {1'b0, denom});
  assign rem_sub = rem_sh - {1'b0, denom};

  // multiplier operands
  assign mul_a      = cmd.mul_cov ? {1'b0, covariance} : mag;
  assign mul_a_half = cmd.mul_hi ? LO_W'(mul_a >> LO_W) : mul_a[LO_W-1:0];
  assign mul_b      = cmd.mul_cov ? (ONE_K - gain) : gain;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate   <= '0;
      covariance <= ONE_D;
    end else begin
      if (cmd.predict) begin
        covariance <= q_sum[DW] ? '1 : q_sum[DW-1:0];
      end else if (cmd.init) begin
        estimate   <= initial_estimate;
        covariance <= initial_covariance;
      end else begin
        if (cmd.est_write) begin
          estimate <= est_sum[DW-1:0];
        end
        if (cmd.cov_write) begin
          covariance <= acc[FRAC_BITS +: DW];
        end
      end
    end
  end

  // gain division and magnitude setup
  always_ff @(posedge clk) begin
    if (cmd.upd_start) begin
      denom <= pr_sum;
      rem   <= {1'b0, covariance};
      neg   <= diff[AW-1];
      mag   <= diff[AW-1] ? (~diff + 1'b1) : diff;
      if (pr_sum == '0) begin
        gain       <= '0;
        gain_fixed <= 1'b1;
      end else if (sensor_noise == '0) begin
        gain       <= ONE_K;
        gain_fixed <= 1'b1;
      end else begin
        gain       <= '0;
        gain_fixed <= 1'b0;
      end
    end else if (cmd.div_step && !gain_fixed) begin
      rem  <= rem_ge ? rem_sub[AW-1:0] : rem_sh[AW-1:0];
      gain <= {gain[KW-2:0], rem_ge};
    end
  end

  // split multiplier and accumulator
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= mul_a_half * mul_b;
    end
    if (cmd.acc_first) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'({prod, {LO_W{1'b0}}});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      estimate_out   <= estimate;
      covariance_out <= covariance;
    end
  end

  `SKF_ASSERT(a_gain_le_one, cmd.mul_go |-> (gain <= ONE_K), "gain above one")
  `SKF_ASSERT_NEVER(a_one_state_op, cmd.predict && cmd.init, "two state ops at once")

endmodule

[hdl/scalar_kalman_filter.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// Random-walk estimator in fixed point: predict, update, init and no-op requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per request. tuser = request kind (0 predict, 1 update,
//   2 init, 3 no-op); tdata = measurement, used on update only.
//   m_axis: one beat per request with the estimate and covariance after it.
//   cfg: register writes (0 Q, 1 R, 2 initial estimate, 3 initial
//   covariance), always ready; write only while no request is in flight.
//   Sequence: predict, init and no-op act on accept and then pass through the
//   finish step; update sets up in the accept step, runs the one-bit-a-cycle
//   gain divider and then the split multiplier, which forms each of the two
//   products in two halves.
//   Flow: one request at a time; a new request is taken only after the last
//   one has loaded its result into the output register.
//   Reset: estimate 0, covariance 1.0, Q 0, R 1.0, initial values 0 and 1.0.
//   Receiver stall: a held result blocks completion of the following
//   request, which waits in its finish step until the beat is taken.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: measurement
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: estimate_out, covariance_out
  output logic [((2 * DATA_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_data
);
  import skf_pkg::*;

  localparam int OUT_TW = ((2 * DATA_WIDTH + 7) / 8) * 8;

  skf_cmd_t                     cmd;
  logic signed [DATA_WIDTH-1:0] estimate_out;
  logic [DATA_WIDTH-1:0]        covariance_out;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = OUT_TW'({covariance_out, estimate_out});

  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  skf_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .measurement    (s_axis_tdata[DATA_WIDTH-1:0]),
    .estimate_out   (estimate_out),
    .covariance_out (covariance_out)
  );

endmodule

[sim/scalar_kalman_filter_test.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives predict, update, init and no-op requests through the stream ports
// and writes the noise and start registers between phases. A local model of
// the filter tracks estimate and covariance, and every result beat is
// compared with it. Both sides idle at random; one phase holds the result
// side off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam int FRAC = 16;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC;
  localparam longint unsigned DATA_MAX = 64'hFFFF_FFFF;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // filter outputs as they sit in m_axis_tdata, estimate in the low half
  typedef struct packed {
    logic [31:0] covariance;
    logic [31:0] estimate;
  } filter_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = REQ_NONE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_PROCESS_NOISE;
  logic [31:0] cfg_data = '0;

  // model copy of registers and filter state, reset values
  logic [31:0] noise_q = 32'd0;
  logic [31:0] noise_r = 32'h0001_0000;
  logic [31:0] start_est = 32'd0;
  logic [31:0] start_cov = 32'h0001_0000;
  logic [31:0] model_est = 32'd0;
  logic [31:0] model_cov = 32'h0001_0000;

  filter_result_t pending_states[$];
  int          fault_count = 0;
  int unsigned cycle_count = 0;
  int          tx_gap_max = 0;
  int          rx_stall_max = 0;
  int          rx_wait = 0;
  int          rx_draw;
  logic        rx_holding = 1'b0;
  event        holdoff_go;

  scalar_kalman_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one request through the filter model; returns the state after it
  function automatic filter_result_t advance_filter(input logic [1:0] kind,
                                                    input logic [31:0] z_bits);
    longint unsigned sum, denom, k, mag, step;
    longint          z, x, diff, x_next;
    filter_result_t  res;
    case (kind)
      REQ_PREDICT: begin
        sum = {32'd0, model_cov} + {32'd0, noise_q};
        model_cov = (sum > DATA_MAX) ? 32'hFFFF_FFFF : sum[31:0];
      end
      REQ_UPDATE: begin
        denom = {32'd0, model_cov} + {32'd0, noise_r};
        if (denom == 0)
          k = 0;
        else if (noise_r == 0)
          k = ONE_Q;
        else
          k = ({32'd0, model_cov} << FRAC) / denom;
        z = {{32{z_bits[31]}}, z_bits};
        x = {{32{model_est[31]}}, model_est};
        diff = z - x;
        mag = (diff < 0) ? -diff : diff;
        // magnitude truncated toward zero
        step = (mag * k) >> FRAC;
        x_next = (diff < 0) ? x - $signed(step) : x + $signed(step);
        model_est = x_next[31:0];
        sum = ({32'd0, model_cov} * (ONE_Q - k)) >> FRAC;
        model_cov = sum[31:0];
      end
      REQ_INIT: begin
        model_est = start_est;
        model_cov = start_cov;
      end
      default: ;
    endcase
    res.estimate = model_est;
    res.covariance = model_cov;
    return res;
  endfunction

  task automatic report_fault(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    fault_count++;
  endtask

  task automatic check_result(input filter_result_t seen);
    filter_result_t want;
    if (pending_states.size() == 0) begin
      report_fault($sformatf("unexpected beat est %h cov %h",
                             seen.estimate, seen.covariance));
      return;
    end
    want = pending_states.pop_front();
    if (seen.estimate !== want.estimate)
      report_fault($sformatf("estimate %h, want %h", seen.estimate, want.estimate));
    if (seen.covariance !== want.covariance)
      report_fault($sformatf("covariance %h, want %h", seen.covariance,
                             want.covariance));
  endtask

  // result side: check each beat, then stall for a random draw up to rx_stall_max
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      rx_draw = rx_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        rx_draw = $urandom_range(0, rx_stall_max);
      end
      rx_wait <= (rx_draw > 0) ? rx_draw - 1 : 0;
      m_axis_tready <= !rx_holding && rx_draw == 0;
    end
  end

  // long hold-off of the result side, counted here
  initial begin
    forever begin
      @(holdoff_go);
      rx_holding <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clk);
      rx_holding <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("scalar_kalman_filter verification failed");
      $finish;
    end
  end

  // one request beat; tvalid is left high, the caller lowers it
  task automatic send_request(input logic [1:0] kind, input logic [31:0] meas);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= meas;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_states.push_back(advance_filter(kind, meas));
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PROCESS_NOISE:    noise_q = value;
      CFG_SENSOR_NOISE:     noise_r = value;
      CFG_INITIAL_ESTIMATE: start_est = value;
      default:              start_cov = value;
    endcase
  endtask

  task automatic configure(input logic [31:0] q, input logic [31:0] r,
                           input logic [31:0] x0, input logic [31:0] p0);
    write_register(CFG_PROCESS_NOISE, q);
    write_register(CFG_SENSOR_NOISE, r);
    write_register(CFG_INITIAL_ESTIMATE, x0);
    write_register(CFG_INITIAL_COVARIANCE, p0);
    cfg_valid <= 1'b0;
  endtask

  // stop offering beats and wait for every pending result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_variance();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1;
      3, 4:    return $urandom_range(0, 32'h0004_0000);
      5:       return $urandom_range(0, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_measurement();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return model_est + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly predict/update, some re-inits and no-ops
  task automatic send_random_item();
    int roll;
    logic [1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < 50)
      kind = REQ_UPDATE;
    else if (roll < 85)
      kind = REQ_PREDICT;
    else if (roll < 93)
      kind = REQ_INIT;
    else
      kind = REQ_NONE;
    send_request(kind, pick_measurement());
  endtask

  // reset values of registers and state, no configuration written
  task automatic test_reset_state();
    send_request(REQ_PREDICT, 32'd0);
    send_request(REQ_UPDATE, 32'h0003_0000);
    send_request(REQ_NONE, 32'hFFFF_FFFF);
    send_request(REQ_INIT, 32'd0);
    drain_results();
  endtask

  // field and register extremes, saturation, unit and zero gain
  task automatic test_directed_extremes();
    // Q max saturates, R zero gives unit gain, P+R zero gives zero gain
    configure(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(REQ_INIT, 32'd0);
    send_request(REQ_PREDICT, 32'd0);
    send_request(REQ_UPDATE, 32'h7FFF_FFFF);
    send_request(REQ_UPDATE, 32'h8000_0000);
    send_request(REQ_PREDICT, 32'h1234_5678);
    send_request(REQ_UPDATE, 32'd0);
    send_request(REQ_NONE, 32'h5555_5555);
    drain_results();
    // P zero against huge R
    configure(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    send_request(REQ_INIT, 32'hAAAA_AAAA);
    send_request(REQ_UPDATE, 32'h8000_0000);
    send_request(REQ_PREDICT, 32'd0);
    send_request(REQ_UPDATE, 32'h7FFF_FFFF);
    drain_results();
    // smallest nonzero noise, covariance at the top
    configure(32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF);
    send_request(REQ_INIT, 32'd0);
    send_request(REQ_UPDATE, 32'hFFFF_FFFF);
    send_request(REQ_UPDATE, 32'h1234_5678);
    send_request(REQ_PREDICT, 32'd0);
    send_request(REQ_PREDICT, 32'd0);
    send_request(REQ_UPDATE, 32'h7FFF_FFFF);
    send_request(REQ_UPDATE, 32'h8000_0000);
    send_request(REQ_NONE, 32'hDEAD_BEEF);
    send_request(REQ_UPDATE, 32'd0);
    drain_results();
  endtask

  // random phases, each with its own register set and idling mix
  task automatic test_random_traffic();
    int phase, n;
    for (phase = 0; phase < 6; phase++) begin
      tx_gap_max = (phase % 2 == 0) ? 11 : 0;
      rx_stall_max = (phase % 3 == 1) ? 0 : 11;
      configure(pick_variance(), pick_variance(), $urandom, pick_variance());
      send_request(REQ_INIT, $urandom);
      for (n = 0; n < 80; n++)
        send_random_item();
      drain_results();
    end
  endtask

  // result side held off while requests keep coming back to back
  task automatic test_backpressure();
    int n;
    tx_gap_max = 0;
    rx_stall_max = 0;
    configure(32'h0000_8000, 32'h0002_0000, 32'hFFF0_0000, 32'h0010_0000);
    -> holdoff_go;
    send_request(REQ_INIT, 32'd0);
    for (n = 0; n < 40; n++)
      send_random_item();
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_extremes();
    test_random_traffic();
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("scalar_kalman_filter verification clean");
    else
      $display("scalar_kalman_filter verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/skf_pkg.sv
hdl/skf_ctrl.sv
hdl/skf_datapath.sv
hdl/scalar_kalman_filter.sv
sim/scalar_kalman_filter_test.sv
